// ===== rtl/ipf_pkg.sv =====
// Package: shared types, constants and codes of the IPv4 packet filter.
package ipf_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [5:0]  DEFAULT_PREFIX_LENGTH = 6'd24;
   localparam logic [5:0]  MAX_PREFIX_LENGTH = 6'd32;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_LEN = 16'd14;
   localparam logic [15:0] IPV4_LEN = 16'd34;
   localparam logic [15:0] SHORT_L4_LEN = 16'd42;
   localparam logic [15:0] TCP_LEN = 16'd54;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   typedef enum logic [3:0] {
      CMD_CLASSIFY   = 4'd0,
      CMD_ADD_IP     = 4'd1,
      CMD_DEL_IP     = 4'd2,
      CMD_ADD_PREFIX = 4'd3,
      CMD_DEL_PREFIX = 4'd4,
      CMD_ADD_PORT   = 4'd5,
      CMD_DEL_PORT   = 4'd6,
      CMD_ADD_RULE   = 4'd7,
      CMD_DEL_RULE   = 4'd8
   } command_type;

   typedef enum logic [1:0] {
      VERDICT_PASS  = 2'd0,
      VERDICT_DROP  = 2'd1,
      VERDICT_BLOCK = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      STAGE_NONE   = 3'd0,
      STAGE_EXACT  = 3'd1,
      STAGE_PREFIX = 3'd2,
      STAGE_SPORT  = 3'd3,
      STAGE_DPORT  = 3'd4,
      STAGE_RULE   = 3'd5
   } stage_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // scan targets of the shared scan unit
   typedef enum logic [2:0] {
      SCAN_EXACT  = 3'd0,
      SCAN_PREFIX = 3'd1,
      SCAN_SPORT  = 3'd2,
      SCAN_DPORT  = 3'd3,
      SCAN_RULE   = 3'd4
   } scan_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_START,
      ST_SCAN,
      ST_SCAN_DONE,
      ST_COUNT_RD,
      ST_COUNT_WR,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [3:0]  command;
      logic [15:0] frame_length;
      logic [15:0] ethertype;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [5:0]  entry_prefix_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [2:0]  match_stage;
      logic [63:0] packet_count;
      logic [63:0] byte_count;
      logic [1:0]  table_status;
   } rsp_type;

   // sequencer to scan unit
   typedef struct packed {
      logic       start;
      scan_type   target;
      logic       prefix_match;
      logic [5:0] look_len;
      logic [5:0] key_len;
      logic [31:0] key_addr;
      logic [15:0] key_port;
      logic [31:0] key_dst;
      logic [15:0] key_dport;
      logic [7:0]  key_proto;
   } scan_req_type;

   // scan unit to sequencer
   typedef struct packed {
      logic             clearing;
      logic             done;
      logic             hit;
      logic [IDX_W-1:0] hit_index;
      logic             free_found;
      logic [IDX_W-1:0] free_index;
   } scan_rsp_type;

   // sequencer to table write port
   typedef struct packed {
      logic             en;
      scan_type         target;
      logic             valid;
      logic [IDX_W-1:0] index;
   } table_wr_type;

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [5:0] l;
      l = (len > MAX_PREFIX_LENGTH) ? MAX_PREFIX_LENGTH : len;
      if (l == 6'd0) return 32'd0;
      return 32'hFFFF_FFFF << (6'd32 - l);
   endfunction

endpackage

// ===== rtl/ipf_scan.sv =====
// Table memories and the shared scan unit that walks them one entry a cycle.
module ipf_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  ipf_pkg::scan_req_type scan_req,
   input  ipf_pkg::table_wr_type table_wr,
   output ipf_pkg::scan_rsp_type scan_rsp
);

   localparam int IDX_W = ipf_pkg::IDX_W;

   // entry memories, valid bit on top where the table has one
   logic [32:0] exact_mem [ipf_pkg::TABLE_DEPTH];
   logic [38:0] prefix_mem [ipf_pkg::TABLE_DEPTH];
   logic [16:0] port_mem [ipf_pkg::TABLE_DEPTH];
   logic [63:0] rule_addr_mem [ipf_pkg::TABLE_DEPTH];
   logic [40:0] rule_pp_mem [ipf_pkg::TABLE_DEPTH];

   logic                 clr_ff;
   logic [IDX_W-1:0]     clr_addr_ff;
   logic                 active_ff, active_in;
   logic                 rd_vld_ff;
   logic [IDX_W:0]       addr_ff, addr_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [32:0]          exact_q;
   logic [38:0]          prefix_q;
   logic [16:0]          port_q;
   logic [63:0]          rule_addr_q;
   logic [40:0]          rule_pp_q;
   logic                 entry_vld;
   logic                 hit_ff, free_ff;
   logic [IDX_W-1:0]     hit_idx_ff, free_idx_ff;
   logic                 done_ff;
   logic                 match;
   logic [15:0]          port_key;
   logic [31:0]          pmask;

   // clearing pass after reset: one entry of every table per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         if (clr_addr_ff == IDX_W'(ipf_pkg::TABLE_DEPTH - 1)) clr_ff <= 1'b0;
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // write path: key fields come straight from the scan request
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         exact_mem[clr_addr_ff] <= '0;
         prefix_mem[clr_addr_ff] <= '0;
         port_mem[clr_addr_ff] <= '0;
         rule_pp_mem[clr_addr_ff] <= '0;
      end else if (table_wr.en) begin
         case (table_wr.target)
            ipf_pkg::SCAN_EXACT: exact_mem[table_wr.index] <=
               {table_wr.valid, scan_req.key_addr};
            ipf_pkg::SCAN_PREFIX: prefix_mem[table_wr.index] <=
               {table_wr.valid, scan_req.key_len,
                scan_req.key_addr & ipf_pkg::prefix_mask(scan_req.key_len)};
            ipf_pkg::SCAN_SPORT: port_mem[table_wr.index] <=
               {table_wr.valid, scan_req.key_port};
            ipf_pkg::SCAN_RULE: begin
               if (table_wr.valid)
                  rule_addr_mem[table_wr.index] <= {scan_req.key_addr, scan_req.key_dst};
               rule_pp_mem[table_wr.index] <=
                  {table_wr.valid, scan_req.key_port, scan_req.key_dport,
                   scan_req.key_proto};
            end
            default: ;
         endcase
      end
   end

   // registered reads at the scan address
   always_ff @(posedge clock) begin
      exact_q <= exact_mem[addr_ff[IDX_W-1:0]];
      prefix_q <= prefix_mem[addr_ff[IDX_W-1:0]];
      port_q <= port_mem[addr_ff[IDX_W-1:0]];
      rule_addr_q <= rule_addr_mem[addr_ff[IDX_W-1:0]];
      rule_pp_q <= rule_pp_mem[addr_ff[IDX_W-1:0]];
      rd_idx_ff <= addr_ff[IDX_W-1:0];
   end

   // valid bit of the entry just read
   always_comb begin
      case (scan_req.target)
         ipf_pkg::SCAN_EXACT: entry_vld = exact_q[32];
         ipf_pkg::SCAN_PREFIX: entry_vld = prefix_q[38];
         ipf_pkg::SCAN_SPORT, ipf_pkg::SCAN_DPORT: entry_vld = port_q[16];
         default: entry_vld = rule_pp_q[40];
      endcase
   end

   // advance the scan address
   always_comb begin
      active_in = active_ff;
      addr_in = addr_ff;
      if (scan_req.start) begin
         active_in = 1'b1;
         addr_in = '0;
      end else if (active_ff) begin
         if (addr_ff == (IDX_W+1)'(ipf_pkg::TABLE_DEPTH - 1)) active_in = 1'b0;
         addr_in = addr_ff + 1'b1;
      end
   end

   // shared compare for the entry just read
   assign port_key = (scan_req.target == ipf_pkg::SCAN_DPORT) ?
                     scan_req.key_dport : scan_req.key_port;
   assign pmask = ipf_pkg::prefix_mask(prefix_q[37:32]);

   always_comb begin
      case (scan_req.target)
         ipf_pkg::SCAN_EXACT: match = exact_q[31:0] == scan_req.key_addr;
         ipf_pkg::SCAN_PREFIX: begin
            if (scan_req.prefix_match)
               match = (prefix_q[37:32] <= scan_req.look_len) &&
                       ((scan_req.key_addr & pmask) == prefix_q[31:0]);
            else
               match = (prefix_q[37:32] == scan_req.key_len) &&
                       ((scan_req.key_addr & ipf_pkg::prefix_mask(scan_req.key_len))
                        == prefix_q[31:0]);
         end
         ipf_pkg::SCAN_SPORT, ipf_pkg::SCAN_DPORT: match = port_q[15:0] == port_key;
         default: match = (rule_addr_q == {scan_req.key_addr, scan_req.key_dst}) &&
                          (rule_pp_q[39:0] == {scan_req.key_port, scan_req.key_dport,
                                               scan_req.key_proto});
      endcase
   end

   // record first hit and first free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         addr_ff <= '0;
         rd_vld_ff <= 1'b0;
         done_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         addr_ff <= addr_in;
         rd_vld_ff <= active_ff && !scan_req.start;
         done_ff <= rd_vld_ff && (rd_idx_ff == IDX_W'(ipf_pkg::TABLE_DEPTH - 1));
         if (scan_req.start) begin
            hit_ff <= 1'b0;
            free_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if (entry_vld && match && !hit_ff) begin
               hit_ff <= 1'b1;
               hit_idx_ff <= rd_idx_ff;
            end
            if (!entry_vld && !free_ff) begin
               free_ff <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
         end
      end
   end

   assign scan_rsp.clearing = clr_ff;
   assign scan_rsp.done = done_ff;
   assign scan_rsp.hit = hit_ff;
   assign scan_rsp.hit_index = hit_idx_ff;
   assign scan_rsp.free_found = free_ff;
   assign scan_rsp.free_index = free_idx_ff;

   a_done_after_read: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> !active_ff && !rd_vld_ff)
      else $error("scan done while still reading");
   a_no_write_while_scan: assert property (@(posedge clock) disable iff (reset)
      table_wr.en |-> !active_ff)
      else $error("table write during scan");
   a_no_scan_while_clear: assert property (@(posedge clock) disable iff (reset)
      scan_req.start |-> !clr_ff)
      else $error("scan started during clearing pass");
   a_no_write_while_clear: assert property (@(posedge clock) disable iff (reset)
      table_wr.en |-> !clr_ff)
      else $error("table write during clearing pass");

endmodule

// ===== rtl/ipv4_packet_filter_classifier.sv =====
// Top level: command sequencer, verdict counters and response register.
//
//   channel  | ports                         | handshake
//   request  | req_start, req_busy, req_data | accept on start && !busy
//   response | rsp_strobe, rsp_data          | one-cycle strobe, no stall
//   config   | csr_we, csr_wdata             | write on csr_we
//
// A table scan goes through its start step, one read per entry, the registered
// read, the hit and free record and the done step. An unknown command goes
// from the decide state straight to the response, a table command runs one
// scan, and a classify runs up to five scans and then updates its counters.
// After reset a clearing pass invalidates every table entry and holds busy
// high; the counters clear at reset.
// The response strobe lasts one cycle and cannot be stalled.
module ipv4_packet_filter_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   output logic             req_busy,
   input  ipf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ipf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);

   ipf_pkg::state_type    state_ff, state_in;
   ipf_pkg::req_type      req_ff;
   ipf_pkg::scan_type     target_ff, target_in;
   ipf_pkg::scan_req_type scan_req;
   ipf_pkg::scan_rsp_type scan_rsp;
   ipf_pkg::table_wr_type table_wr;
   ipf_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_vld_ff;
   logic [5:0]            look_ff;
   logic [1:0]            verdict_ff, verdict_in;
   logic [2:0]            stage_ff, stage_in;
   logic [1:0]            status_ff, status_in;
   logic [63:0]           pkt_cnt_ff [3];
   logic [63:0]           byte_cnt_ff [3];
   logic [63:0]           pkt_new_ff, byte_new_ff;
   logic [15:0]           sport_eff, dport_eff;
   logic [5:0]            elen;
   logic                  is_add, cmd_valid;
   logic                  l4_short;
   logic                  accept;

   // config register
   always_ff @(posedge clock) begin
      if (reset) look_ff <= ipf_pkg::DEFAULT_PREFIX_LENGTH;
      else if (csr_we) look_ff <= csr_wdata;
   end

   assign accept = req_start && !req_busy;
   assign elen = (req_ff.entry_prefix_length > ipf_pkg::MAX_PREFIX_LENGTH) ?
                 ipf_pkg::MAX_PREFIX_LENGTH : req_ff.entry_prefix_length;
   assign is_add = req_ff.command[0];
   assign cmd_valid = req_ff.command <= 4'(ipf_pkg::CMD_DEL_RULE);
   assign l4_short = (req_ff.protocol == ipf_pkg::PROTO_TCP) ?
                     (req_ff.frame_length < ipf_pkg::TCP_LEN) :
                     (req_ff.frame_length < ipf_pkg::SHORT_L4_LEN);
   // ICMP sees zero ports
   assign sport_eff = (req_ff.protocol == ipf_pkg::PROTO_ICMP) ? 16'd0 : req_ff.source_port;
   assign dport_eff = (req_ff.protocol == ipf_pkg::PROTO_ICMP) ? 16'd0 : req_ff.dest_port;

   // scan key
   always_comb begin
      scan_req.start = state_ff == ipf_pkg::ST_SCAN_START;
      scan_req.target = target_ff;
      scan_req.prefix_match = req_ff.command == 4'(ipf_pkg::CMD_CLASSIFY);
      scan_req.look_len = (look_ff > ipf_pkg::MAX_PREFIX_LENGTH) ?
                          ipf_pkg::MAX_PREFIX_LENGTH : look_ff;
      scan_req.key_len = elen;
      scan_req.key_addr = req_ff.source_address;
      scan_req.key_dst = req_ff.dest_address;
      scan_req.key_port = (req_ff.command == 4'(ipf_pkg::CMD_CLASSIFY)) ?
                          sport_eff : req_ff.source_port;
      scan_req.key_dport = (req_ff.command == 4'(ipf_pkg::CMD_CLASSIFY)) ?
                           dport_eff : req_ff.dest_port;
      scan_req.key_proto = req_ff.protocol;
   end

   ipf_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .table_wr (table_wr),
      .scan_rsp (scan_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      target_in = target_ff;
      verdict_in = verdict_ff;
      stage_in = stage_ff;
      status_in = status_ff;
      case (state_ff)
         ipf_pkg::ST_IDLE: begin
            if (accept) state_in = ipf_pkg::ST_DECIDE;
         end
         ipf_pkg::ST_DECIDE: begin
            verdict_in = ipf_pkg::VERDICT_PASS;
            stage_in = ipf_pkg::STAGE_NONE;
            status_in = ipf_pkg::STATUS_OK;
            state_in = ipf_pkg::ST_SCAN_START;
            case (req_ff.command)
               ipf_pkg::CMD_CLASSIFY: begin
                  target_in = ipf_pkg::SCAN_EXACT;
                  if (req_ff.frame_length < ipf_pkg::ETH_LEN) begin
                     verdict_in = ipf_pkg::VERDICT_DROP;
                     state_in = ipf_pkg::ST_COUNT_RD;
                  end else if (req_ff.ethertype != ipf_pkg::ETHERTYPE_IPV4) begin
                     state_in = ipf_pkg::ST_COUNT_RD;
                  end else if (req_ff.frame_length < ipf_pkg::IPV4_LEN) begin
                     verdict_in = ipf_pkg::VERDICT_DROP;
                     state_in = ipf_pkg::ST_COUNT_RD;
                  end else if (req_ff.protocol != ipf_pkg::PROTO_ICMP &&
                               req_ff.protocol != ipf_pkg::PROTO_TCP &&
                               req_ff.protocol != ipf_pkg::PROTO_UDP) begin
                     state_in = ipf_pkg::ST_COUNT_RD;
                  end
               end
               ipf_pkg::CMD_ADD_IP, ipf_pkg::CMD_DEL_IP: target_in = ipf_pkg::SCAN_EXACT;
               ipf_pkg::CMD_ADD_PREFIX, ipf_pkg::CMD_DEL_PREFIX:
                  target_in = ipf_pkg::SCAN_PREFIX;
               ipf_pkg::CMD_ADD_PORT, ipf_pkg::CMD_DEL_PORT: target_in = ipf_pkg::SCAN_SPORT;
               ipf_pkg::CMD_ADD_RULE, ipf_pkg::CMD_DEL_RULE: target_in = ipf_pkg::SCAN_RULE;
               default: state_in = ipf_pkg::ST_RESPOND;
            endcase
         end
         ipf_pkg::ST_SCAN_START: state_in = ipf_pkg::ST_SCAN;
         ipf_pkg::ST_SCAN: begin
            if (scan_rsp.done) state_in = ipf_pkg::ST_SCAN_DONE;
         end
         ipf_pkg::ST_SCAN_DONE: begin
            if (req_ff.command != 4'(ipf_pkg::CMD_CLASSIFY)) begin
               if (is_add) begin
                  if (!scan_rsp.hit && !scan_rsp.free_found) status_in = ipf_pkg::STATUS_FULL;
               end else if (!scan_rsp.hit) begin
                  status_in = ipf_pkg::STATUS_NOT_FOUND;
               end
               state_in = ipf_pkg::ST_RESPOND;
            end else if (scan_rsp.hit) begin
               verdict_in = ipf_pkg::VERDICT_BLOCK;
               case (target_ff)
                  ipf_pkg::SCAN_EXACT: stage_in = ipf_pkg::STAGE_EXACT;
                  ipf_pkg::SCAN_PREFIX: stage_in = ipf_pkg::STAGE_PREFIX;
                  ipf_pkg::SCAN_SPORT: stage_in = ipf_pkg::STAGE_SPORT;
                  ipf_pkg::SCAN_DPORT: stage_in = ipf_pkg::STAGE_DPORT;
                  default: stage_in = ipf_pkg::STAGE_RULE;
               endcase
               state_in = ipf_pkg::ST_COUNT_RD;
            end else begin
               state_in = ipf_pkg::ST_SCAN_START;
               case (target_ff)
                  ipf_pkg::SCAN_EXACT: target_in = ipf_pkg::SCAN_PREFIX;
                  ipf_pkg::SCAN_PREFIX: begin
                     if (l4_short) begin
                        verdict_in = ipf_pkg::VERDICT_DROP;
                        state_in = ipf_pkg::ST_COUNT_RD;
                     end else if (sport_eff != 16'd0) begin
                        target_in = ipf_pkg::SCAN_SPORT;
                     end else if (dport_eff != 16'd0) begin
                        target_in = ipf_pkg::SCAN_DPORT;
                     end else begin
                        target_in = ipf_pkg::SCAN_RULE;
                     end
                  end
                  ipf_pkg::SCAN_SPORT: target_in = (dport_eff != 16'd0) ?
                                       ipf_pkg::SCAN_DPORT : ipf_pkg::SCAN_RULE;
                  ipf_pkg::SCAN_DPORT: target_in = ipf_pkg::SCAN_RULE;
                  default: state_in = ipf_pkg::ST_COUNT_RD;
               endcase
            end
         end
         ipf_pkg::ST_COUNT_RD: state_in = ipf_pkg::ST_COUNT_WR;
         ipf_pkg::ST_COUNT_WR: state_in = ipf_pkg::ST_RESPOND;
         ipf_pkg::ST_RESPOND: state_in = ipf_pkg::ST_IDLE;
         default: state_in = ipf_pkg::ST_IDLE;
      endcase
   end

   // table write decision
   always_comb begin
      table_wr.en = 1'b0;
      table_wr.target = target_ff;
      table_wr.valid = is_add;
      table_wr.index = is_add ? scan_rsp.free_index : scan_rsp.hit_index;
      if (state_ff == ipf_pkg::ST_SCAN_DONE && cmd_valid &&
          req_ff.command != 4'(ipf_pkg::CMD_CLASSIFY)) begin
         if (is_add) table_wr.en = !scan_rsp.hit && scan_rsp.free_found;
         else table_wr.en = scan_rsp.hit;
      end
   end

   // hold request and sequencer registers
   always_ff @(posedge clock) begin
      if (accept && state_ff == ipf_pkg::ST_IDLE) req_ff <= req_data;
      target_ff <= target_in;
      verdict_ff <= verdict_in;
      stage_ff <= stage_in;
      status_ff <= status_in;
      if (state_ff == ipf_pkg::ST_COUNT_RD) begin
         pkt_new_ff <= pkt_cnt_ff[verdict_ff] + 64'd1;
         byte_new_ff <= byte_cnt_ff[verdict_ff] + {48'd0, req_ff.frame_length};
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            pkt_cnt_ff[k] <= '0;
            byte_cnt_ff[k] <= '0;
         end
      end else if (state_ff == ipf_pkg::ST_COUNT_WR) begin
         pkt_cnt_ff[verdict_ff] <= pkt_new_ff;
         byte_cnt_ff[verdict_ff] <= byte_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipf_pkg::ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_vld_ff <= state_ff == ipf_pkg::ST_RESPOND;
      end
   end

   // build the response payload
   always_comb begin
      rsp_in = '0;
      if (req_ff.command == 4'(ipf_pkg::CMD_CLASSIFY)) begin
         rsp_in.verdict = verdict_ff;
         rsp_in.match_stage = stage_ff;
         rsp_in.packet_count = pkt_new_ff;
         rsp_in.byte_count = byte_new_ff;
      end else if (cmd_valid) begin
         rsp_in.table_status = status_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == ipf_pkg::ST_RESPOND) rsp_ff <= rsp_in;
   end

   assign req_busy = (state_ff != ipf_pkg::ST_IDLE) || scan_rsp.clearing;
   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data = rsp_ff;

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ipf_pkg::ST_IDLE)
      else $error("response while busy");
   a_stage_block: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.match_stage != 3'd0 |->
      rsp_data.verdict == ipf_pkg::VERDICT_BLOCK)
      else $error("match stage without block");

endmodule
